### design/assert_macros.svh
// Assertion macros shared by the layered hash noise RTL.
// No dependencies; synthesis builds define SYNTH to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LHN_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define LHN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define LHN_ASSERT(lbl, clk, rstn, prop, msg)
`define LHN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### design/lhn_pkg.sv
// Types and constants for the layered hash noise pipeline.
// Used by lhn_cell_div, lhn_hash and layered_hash_noise_core.
package lhn_pkg;

    localparam int LAYERS     = 3;
    localparam int PIPE_DEPTH = 8;

    typedef logic signed [15:0] coord_t;
    typedef logic [15:0]        mag_t;
    typedef logic [31:0]        word_t;
    typedef logic [13:0]        quot_t;
    typedef logic [7:0]         byte_t;
    typedef logic [15:0]        sum_t;

    localparam word_t MIX_X = 32'd374761393;
    localparam word_t MIX_Y = 32'd668265263;
    localparam word_t MIX_S = 32'd1442695041;
    localparam word_t MIX_F = 32'd1274126177;

    localparam word_t SALT_OFS [LAYERS] = '{32'd0, 32'd11, 32'd29};

    // ceil(2^32 / d): exact floor division for magnitudes up to 2^15
    localparam logic [63:0] TWO32 = 64'h0000_0001_0000_0000;
    localparam word_t RECIP_X [LAYERS] = '{
        word_t'((TWO32 + 64'd4)  / 64'd5),
        word_t'((TWO32 + 64'd11) / 64'd12),
        word_t'((TWO32 + 64'd22) / 64'd23)
    };
    localparam word_t RECIP_Y [LAYERS] = '{
        word_t'((TWO32 + 64'd3)  / 64'd4),
        word_t'((TWO32 + 64'd8)  / 64'd9),
        word_t'((TWO32 + 64'd16) / 64'd17)
    };

    localparam sum_t W_A       = 16'd100;
    localparam sum_t W_B       = 16'd65;
    localparam sum_t W_C       = 16'd35;
    localparam sum_t NOISE_MAX = 16'd51000;

endpackage

### design/layered_hash_noise_core.sv
// Top level of the layered hash noise pipeline: cell division, three hash
// lanes and the weighted sum. Depends on lhn_pkg, lhn_cell_div, lhn_hash.
//
// Takes one transaction per clock while in_stall is low and returns one
// noise_sum per transaction, in order. The result shows on out_valid when it
// leaves the last of eight register stages, and the first one loads at the
// accepting edge. Three stages form the grid cells (coordinate magnitude,
// reciprocal multiply, sign restore and salt offset). Four stages run the three
// cell hashes side by side, and the last stage forms 100*a + 65*b + 35*c in the
// output register. A stall on the result side freezes the whole pipeline in the
// same cycle and is shown to the source as in_stall; bubbles are not squeezed
// out. The block has no state beyond the pipeline, so reset only clears the
// valid bits.
`include "assert_macros.svh"

module layered_hash_noise_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  lhn_pkg::coord_t coord_x,
    input  lhn_pkg::coord_t coord_y,
    input  lhn_pkg::word_t  salt,
    output logic            out_valid,
    input  logic            out_stall,
    output lhn_pkg::sum_t   noise_sum
);
    import lhn_pkg::*;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic                  advance;

    word_t cell_x [LAYERS];
    word_t cell_y [LAYERS];
    word_t salt_word [LAYERS];
    byte_t hash_byte [LAYERS];

    sum_t sum_reg;
    sum_t sum_next;

    // advance unless a finished result is held by the consumer
    assign advance  = !(vld_reg[PIPE_DEPTH-1] && out_stall);
    assign in_stall = !advance;
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], in_valid};

    lhn_cell_div u_cell_div
    (
        .clk       (clk),
        .advance   (advance),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .salt      (salt),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .salt_word (salt_word)
    );

    for (genvar g = 0; g < LAYERS; g++)
    begin : g_lane
        lhn_hash u_hash
        (
            .clk       (clk),
            .advance   (advance),
            .cell_x    (cell_x[g]),
            .cell_y    (cell_y[g]),
            .salt_word (salt_word[g]),
            .hash_byte (hash_byte[g])
        );
    end

    assign sum_next = sum_t'(hash_byte[0]) * W_A
                    + sum_t'(hash_byte[1]) * W_B
                    + sum_t'(hash_byte[2]) * W_C;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign noise_sum = sum_reg;

    `LHN_ASSERT(a_sum_range, clk, rst_n, !out_valid || (noise_sum <= NOISE_MAX), "noise_sum out of range")
    `LHN_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, vld_reg[0], "accepted transaction lost at entry")
    `LHN_ASSERT_NEXT(a_stall_freezes, clk, rst_n, out_valid && out_stall, $stable(vld_reg), "pipeline moved while stalled")

endmodule

### design/lhn_cell_div.sv
// Three-stage grid cell front end: magnitude, reciprocal multiply, sign restore.
// Depends on lhn_pkg for divisor reciprocals and salt offsets.
module lhn_cell_div
(
    input  logic            clk,
    input  logic            advance,
    input  lhn_pkg::coord_t coord_x,
    input  lhn_pkg::coord_t coord_y,
    input  lhn_pkg::word_t  salt,
    output lhn_pkg::word_t  cell_x [lhn_pkg::LAYERS],
    output lhn_pkg::word_t  cell_y [lhn_pkg::LAYERS],
    output lhn_pkg::word_t  salt_word [lhn_pkg::LAYERS]
);
    import lhn_pkg::*;

    mag_t  xa_reg, ya_reg;
    logic  xn_reg, yn_reg;
    word_t salt_a_reg;

    quot_t qx_reg [LAYERS];
    quot_t qy_reg [LAYERS];
    logic  xn_b_reg, yn_b_reg;
    word_t salt_b_reg;

    word_t cx_reg [LAYERS];
    word_t cy_reg [LAYERS];
    word_t sw_reg [LAYERS];

    mag_t        xa_next, ya_next;
    logic [47:0] px [LAYERS];
    logic [47:0] py [LAYERS];

    // magnitude of the most negative code is 2^15, still fits unsigned
    assign xa_next = coord_x[15] ? mag_t'(~coord_x + 16'd1) : mag_t'(coord_x);
    assign ya_next = coord_y[15] ? mag_t'(~coord_y + 16'd1) : mag_t'(coord_y);

    always_comb
    begin
        for (int i = 0; i < LAYERS; i++)
        begin
            px[i] = 48'(xa_reg) * 48'(RECIP_X[i]);
            py[i] = 48'(ya_reg) * 48'(RECIP_Y[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xa_reg     <= xa_next;
            ya_reg     <= ya_next;
            xn_reg     <= coord_x[15];
            yn_reg     <= coord_y[15];
            salt_a_reg <= salt;

            for (int i = 0; i < LAYERS; i++)
            begin
                qx_reg[i] <= px[i][45:32];
                qy_reg[i] <= py[i][45:32];
            end
            xn_b_reg   <= xn_reg;
            yn_b_reg   <= yn_reg;
            salt_b_reg <= salt_a_reg;

            // negate the magnitude quotient: truncation toward zero
            for (int i = 0; i < LAYERS; i++)
            begin
                cx_reg[i] <= xn_b_reg ? (32'd0 - word_t'(qx_reg[i])) : word_t'(qx_reg[i]);
                cy_reg[i] <= yn_b_reg ? (32'd0 - word_t'(qy_reg[i])) : word_t'(qy_reg[i]);
                sw_reg[i] <= salt_b_reg + SALT_OFS[i];
            end
        end
    end

    assign cell_x    = cx_reg;
    assign cell_y    = cy_reg;
    assign salt_word = sw_reg;

endmodule

### design/lhn_hash.sv
// Four-stage multiply/xor/shift cell hash, returning the low byte of the mix.
// Depends on lhn_pkg for the mixing constants.
module lhn_hash
(
    input  logic           clk,
    input  logic           advance,
    input  lhn_pkg::word_t cell_x,
    input  lhn_pkg::word_t cell_y,
    input  lhn_pkg::word_t salt_word,
    output lhn_pkg::byte_t hash_byte
);
    import lhn_pkg::*;

    word_t px_reg, py_reg, ps_reg;
    word_t mix_reg;
    word_t fin_reg;
    byte_t byte_reg;

    word_t lin_sum;

    assign lin_sum = px_reg + py_reg + ps_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg   <= cell_x * MIX_X;
            py_reg   <= cell_y * MIX_Y;
            ps_reg   <= salt_word * MIX_S;
            mix_reg  <= lin_sum ^ (lin_sum >> 13);
            fin_reg  <= mix_reg * MIX_F;
            // low byte of h ^ (h >> 16)
            byte_reg <= fin_reg[7:0] ^ fin_reg[23:16];
        end
    end

    assign hash_byte = byte_reg;

endmodule
